### rtl/core/bbe_pkg.sv
// Shared types and constants of the edge-aware 3x3 box blur.
// No dependencies.
package bbe_pkg;

  localparam int ChanW    = 8;
  localparam int PixW     = 3 * ChanW;
  localparam int SumW     = 12;
  localparam int CntW     = 4;
  localparam int DvdW     = 13;
  localparam int RemW     = 5;
  localparam int FwW      = 11;
  localparam int FhW      = 16;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] RegFrameWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegFrameHeight = 2'd1;

  localparam logic OpPixel = 1'b0;
  localparam logic OpDrain = 1'b1;

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StScan  = 6'b000010,
    StFlush = 6'b000100,
    StDivGo = 6'b001000,
    StDiv   = 6'b010000,
    StEmit  = 6'b100000
  } bbe_state_e;

  typedef struct packed {
    logic                      start;
    logic [CntW-1:0]           n;
    logic [2:0][SumW-1:0]      sum;
  } bbe_div_req_t;

  typedef struct packed {
    logic                      busy;
    logic                      done;
    logic [2:0][ChanW-1:0]     quot;
  } bbe_div_rsp_t;

  function automatic logic [1:0] slot_prev(input logic [1:0] s);
    return (s == 2'd0) ? 2'd2 : s - 2'd1;
  endfunction

  function automatic logic [1:0] slot_next(input logic [1:0] s);
    return (s == 2'd2) ? 2'd0 : s + 2'd1;
  endfunction

endpackage

### rtl/core/bbe_line_mem.sv
// Line buffer RAM: three rows of packed RGB pixels, one write and one read port.
// Depends on bbe_pkg.
module bbe_line_mem #(
  parameter int AW = 12
) (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [AW-1:0]           waddr_i,
  input  logic [bbe_pkg::PixW-1:0] wdata_i,
  input  logic                    re_i,
  input  logic [AW-1:0]           raddr_i,
  output logic [bbe_pkg::PixW-1:0] rdata_o
);

  logic [bbe_pkg::PixW-1:0] mem [2**AW];
  logic [bbe_pkg::PixW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/bbe_div.sv
// Rounded mean divider: (2*sum + n) / (2*n) for three channels, one bit a cycle.
// Depends on bbe_pkg.
module bbe_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bbe_pkg::bbe_div_req_t req_i,
  output bbe_pkg::bbe_div_rsp_t rsp_o
);

  logic                                  busy_q, busy_d;
  logic                                  done_q, done_d;
  logic [bbe_pkg::CntW-1:0]              cnt_q, cnt_d;
  logic [2:0][bbe_pkg::DvdW-1:0]         dvd_q, dvd_d;
  logic [2:0][bbe_pkg::RemW-1:0]         rem_q, rem_d;
  logic [bbe_pkg::RemW-1:0]              dsr_q, dsr_d;
  logic [bbe_pkg::RemW:0]                rem_sh [3];
  logic                                  ge [3];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    for (int i = 0; i < 3; i++) begin
      rem_sh[i] = {rem_q[i], dvd_q[i][bbe_pkg::DvdW-1]};
      ge[i]     = rem_sh[i] >= {1'b0, dsr_q};
    end
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dsr_d  = {req_i.n, 1'b0};
      for (int i = 0; i < 3; i++) begin
        dvd_d[i] = {req_i.sum[i], 1'b0} + bbe_pkg::DvdW'(req_i.n);
        rem_d[i] = '0;
      end
    end else if (busy_q) begin
      for (int i = 0; i < 3; i++) begin
        rem_d[i] = ge[i] ? bbe_pkg::RemW'(rem_sh[i] - {1'b0, dsr_q})
                         : rem_sh[i][bbe_pkg::RemW-1:0];
        dvd_d[i] = {dvd_q[i][bbe_pkg::DvdW-2:0], ge[i]};
      end
      if (cnt_q == bbe_pkg::CntW'(bbe_pkg::DvdW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  always_comb begin
    rsp_o.busy = busy_q;
    rsp_o.done = done_q;
    for (int i = 0; i < 3; i++) begin
      rsp_o.quot[i] = dvd_q[i][bbe_pkg::ChanW-1:0];
    end
  end

endmodule

### rtl/core/box_blur_3x3_edge_aware.sv
// Edge-aware 3x3 box blur over an RGB raster stream; each output is the rounded
// mean of the in-frame neighbors. Uses bbe_pkg, bbe_line_mem and bbe_div.
// Timing: one item at a time. A pixel beat is written to the line RAM on accept;
// each output it causes is made by a scan of the 3x3 RAM positions, a flush, a
// divider start, the divide and the emit into the output register. A pixel beat
// causes zero, one or two outputs, a drain beat at most one. The single RAM read
// port sets the scan length. The line RAM needs no clearing after reset.
module box_blur_3x3_edge_aware #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bbe_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [bbe_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          opcode_i,
  input  logic [bbe_pkg::ChanW-1:0]     red_in_i,
  input  logic [bbe_pkg::ChanW-1:0]     green_in_i,
  input  logic [bbe_pkg::ChanW-1:0]     blue_in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [bbe_pkg::ChanW-1:0]     red_out_o,
  output logic [bbe_pkg::ChanW-1:0]     green_out_o,
  output logic [bbe_pkg::ChanW-1:0]     blue_out_o,
  output logic                          frame_end_o
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int CW1 = $clog2(MAX_WIDTH + 1);
  localparam int CXW = CW1 + 1;
  localparam int AW  = CW + 2;

  bbe_pkg::bbe_state_e state_q, state_d;

  logic [bbe_pkg::FwW-1:0] fw_q, fw_d;
  logic [bbe_pkg::FhW-1:0] fh_q, fh_d;
  logic [CW1-1:0]          w_eff;
  logic [bbe_pkg::FhW-1:0] h_eff;

  logic [CW-1:0]           col_q, col_d;
  logic [bbe_pkg::FhW-1:0] row_q, row_d;
  logic [1:0]              slot_q, slot_d;
  logic [CW1-1:0]          pend_q, pend_d;

  logic [CW-1:0]           jcol_q, jcol_d;
  logic                    second_q, second_d;
  logic                    last_q, last_d;
  logic                    top_vld_q, top_vld_d;
  logic                    bot_vld_q, bot_vld_d;
  logic [1:0]              slot_top_q, slot_top_d;
  logic [1:0]              slot_mid_q, slot_mid_d;
  logic [1:0]              slot_bot_q, slot_bot_d;

  logic [1:0]                       dr_q, dr_d, dc_q, dc_d;
  logic                             rdv_q, rdv_d;
  logic [2:0][bbe_pkg::SumW-1:0]    acc_q, acc_d;
  logic [bbe_pkg::CntW-1:0]         n_q, n_d;

  logic                             out_valid_q, out_valid_d;
  logic [2:0][bbe_pkg::ChanW-1:0]   out_pix_q, out_pix_d;
  logic                             out_end_q, out_end_d;

  logic                    in_acc, cfg_acc, pix_ok, c_last, load_out;
  logic                    mem_we, mem_re, pos_rvld, pos_cvld;
  logic [AW-1:0]           mem_waddr, mem_raddr;
  logic [bbe_pkg::PixW-1:0] mem_rdata;
  logic [1:0]              pos_slot;
  logic [CXW-1:0]          cc_ext;

  bbe_pkg::bbe_div_req_t div_req;
  bbe_pkg::bbe_div_rsp_t div_rsp;

  always_comb begin
    if (fw_q == '0) begin
      w_eff = CW1'(1);
    end else if (32'(fw_q) > 32'(MAX_WIDTH)) begin
      w_eff = CW1'(MAX_WIDTH);
    end else begin
      w_eff = CW1'(fw_q);
    end
    h_eff = (fh_q == '0) ? bbe_pkg::FhW'(1) : fh_q;
  end

  // a pending config beat wins over the input
  assign in_ready_o  = (state_q == bbe_pkg::StIdle) && !cfg_valid_i;
  assign cfg_ready_o = (state_q == bbe_pkg::StIdle);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;

  assign pix_ok  = (pend_q == '0) && (row_q < h_eff) && (CW1'(col_q) < w_eff);
  assign c_last  = (CXW'(col_q) + CXW'(1)) == CXW'(w_eff);
  assign mem_we  = in_acc && (opcode_i == bbe_pkg::OpPixel) && pix_ok;
  assign mem_waddr = {slot_q, col_q};

  // scan position
  always_comb begin
    unique case (dr_q)
      2'd0:    begin pos_rvld = top_vld_q; pos_slot = slot_top_q; end
      2'd1:    begin pos_rvld = 1'b1;      pos_slot = slot_mid_q; end
      default: begin pos_rvld = bot_vld_q; pos_slot = slot_bot_q; end
    endcase
    cc_ext    = CXW'(jcol_q) + CXW'(dc_q);
    pos_cvld  = (cc_ext != '0) && ((cc_ext - CXW'(1)) < CXW'(w_eff));
    mem_re    = (state_q == bbe_pkg::StScan) && pos_rvld && pos_cvld;
    mem_raddr = {pos_slot, CW'(cc_ext - CXW'(1))};
  end

  assign load_out = (state_q == bbe_pkg::StEmit) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d    = state_q;
    fw_d       = fw_q;
    fh_d       = fh_q;
    col_d      = col_q;
    row_d      = row_q;
    slot_d     = slot_q;
    pend_d     = pend_q;
    jcol_d     = jcol_q;
    second_d   = second_q;
    last_d     = last_q;
    top_vld_d  = top_vld_q;
    bot_vld_d  = bot_vld_q;
    slot_top_d = slot_top_q;
    slot_mid_d = slot_mid_q;
    slot_bot_d = slot_bot_q;
    dr_d       = dr_q;
    dc_d       = dc_q;
    rdv_d      = 1'b0;
    acc_d      = acc_q;
    n_d        = n_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_pix_d  = out_pix_q;
    out_end_d  = out_end_q;
    div_req.start = 1'b0;
    div_req.n     = (n_q == '0) ? bbe_pkg::CntW'(1) : n_q;
    div_req.sum   = acc_q;

    if (state_q == bbe_pkg::StScan || state_q == bbe_pkg::StFlush) begin
      if (rdv_q) begin
        acc_d[0] = acc_q[0] + bbe_pkg::SumW'(mem_rdata[23:16]);
        acc_d[1] = acc_q[1] + bbe_pkg::SumW'(mem_rdata[15:8]);
        acc_d[2] = acc_q[2] + bbe_pkg::SumW'(mem_rdata[7:0]);
        n_d      = n_q + 1'b1;
      end
    end

    unique case (state_q)
      bbe_pkg::StIdle: begin
        dr_d  = '0;
        dc_d  = '0;
        acc_d = '0;
        n_d   = '0;
        if (cfg_acc) begin
          if (cfg_index_i == bbe_pkg::RegFrameWidth) begin
            fw_d = cfg_data_i[bbe_pkg::FwW-1:0];
          end
          if (cfg_index_i == bbe_pkg::RegFrameHeight) begin
            fh_d = cfg_data_i;
          end
          if (cfg_index_i == bbe_pkg::RegFrameWidth ||
              cfg_index_i == bbe_pkg::RegFrameHeight) begin
            col_d  = '0;
            row_d  = '0;
            slot_d = '0;
            pend_d = '0;
          end
        end else if (in_acc && opcode_i == bbe_pkg::OpPixel && pix_ok) begin
          slot_bot_d = slot_q;
          slot_mid_d = bbe_pkg::slot_prev(slot_q);
          slot_top_d = bbe_pkg::slot_prev(bbe_pkg::slot_prev(slot_q));
          top_vld_d  = row_q >= bbe_pkg::FhW'(2);
          bot_vld_d  = 1'b1;
          last_d     = 1'b0;
          if (row_q != '0 && col_q != '0) begin
            jcol_d   = col_q - 1'b1;
            second_d = c_last;
            state_d  = bbe_pkg::StScan;
          end else if (row_q != '0 && c_last) begin
            jcol_d   = col_q;
            second_d = 1'b0;
            state_d  = bbe_pkg::StScan;
          end
          if (c_last) begin
            col_d  = '0;
            row_d  = row_q + 1'b1;
            slot_d = bbe_pkg::slot_next(slot_q);
            if ((row_q + 1'b1) == h_eff) begin
              pend_d = w_eff;
            end
          end else begin
            col_d = col_q + 1'b1;
          end
        end else if (in_acc && opcode_i == bbe_pkg::OpDrain && pend_q != '0) begin
          jcol_d     = CW'(w_eff - pend_q);
          last_d     = (pend_q == CW1'(1));
          second_d   = 1'b0;
          top_vld_d  = h_eff >= bbe_pkg::FhW'(2);
          bot_vld_d  = 1'b0;
          slot_mid_d = bbe_pkg::slot_prev(slot_q);
          slot_top_d = bbe_pkg::slot_prev(bbe_pkg::slot_prev(slot_q));
          slot_bot_d = slot_q;
          pend_d     = pend_q - 1'b1;
          if (pend_q == CW1'(1)) begin
            row_d  = '0;
            col_d  = '0;
            slot_d = '0;
          end
          state_d = bbe_pkg::StScan;
        end
      end
      bbe_pkg::StScan: begin
        rdv_d = mem_re;
        if (dc_q == 2'd2) begin
          dc_d = '0;
          if (dr_q == 2'd2) begin
            state_d = bbe_pkg::StFlush;
          end else begin
            dr_d = dr_q + 1'b1;
          end
        end else begin
          dc_d = dc_q + 1'b1;
        end
      end
      bbe_pkg::StFlush: begin
        state_d = bbe_pkg::StDivGo;
      end
      bbe_pkg::StDivGo: begin
        div_req.start = 1'b1;
        state_d       = bbe_pkg::StDiv;
      end
      bbe_pkg::StDiv: begin
        if (div_rsp.done) begin
          state_d = bbe_pkg::StEmit;
        end
      end
      bbe_pkg::StEmit: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          out_pix_d   = div_rsp.quot;
          out_end_d   = last_q;
          dr_d  = '0;
          dc_d  = '0;
          acc_d = '0;
          n_d   = '0;
          if (second_q) begin
            jcol_d   = jcol_q + 1'b1;
            second_d = 1'b0;
            state_d  = bbe_pkg::StScan;
          end else begin
            state_d = bbe_pkg::StIdle;
          end
        end
      end
      default: begin
        state_d = bbe_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bbe_pkg::StIdle;
      fw_q        <= bbe_pkg::FwW'(1024);
      fh_q        <= bbe_pkg::FhW'(1024);
      col_q       <= '0;
      row_q       <= '0;
      slot_q      <= '0;
      pend_q      <= '0;
      second_q    <= 1'b0;
      last_q      <= 1'b0;
      rdv_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fw_q        <= fw_d;
      fh_q        <= fh_d;
      col_q       <= col_d;
      row_q       <= row_d;
      slot_q      <= slot_d;
      pend_q      <= pend_d;
      second_q    <= second_d;
      last_q      <= last_d;
      rdv_q       <= rdv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    jcol_q     <= jcol_d;
    top_vld_q  <= top_vld_d;
    bot_vld_q  <= bot_vld_d;
    slot_top_q <= slot_top_d;
    slot_mid_q <= slot_mid_d;
    slot_bot_q <= slot_bot_d;
    dr_q       <= dr_d;
    dc_q       <= dc_d;
    acc_q      <= acc_d;
    n_q        <= n_d;
    out_pix_q  <= out_pix_d;
    out_end_q  <= out_end_d;
  end

  bbe_line_mem #(
    .AW(AW)
  ) u_line_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i ({red_in_i, green_in_i, blue_in_i}),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  bbe_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign out_valid_o = out_valid_q;
  assign red_out_o   = out_pix_q[0];
  assign green_out_o = out_pix_q[1];
  assign blue_out_o  = out_pix_q[2];
  assign frame_end_o = out_end_q;

  a_pend_in_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= w_eff) else $error("pending outputs exceed frame width");

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q != 2'd3) else $error("row slot out of range");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bbe_pkg::StDiv && div_rsp.done) |-> n_q != '0)
    else $error("mean taken over an empty neighborhood");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten");

endmodule

### verif/tb.sv
// Self-checking testbench of box_blur_3x3_edge_aware: clocked driver and monitor,
// with a built-in blur predictor checking every output beat.
// Depends on bbe_pkg and the box_blur_3x3_edge_aware RTL.
module tb;

  localparam int MaxW = 1024;
  localparam int QuietCycles = 120;
  localparam int WatchdogLimit = 40000;
  localparam logic [bbe_pkg::CfgIdxW-1:0] RegSpare2 = 2'd2;
  localparam logic [bbe_pkg::CfgIdxW-1:0] RegSpare3 = 2'd3;

  typedef enum logic [1:0] {KPix, KCfg, KSync} step_kind_e;

  typedef struct {
    step_kind_e                   kind;
    logic                         op;
    logic [bbe_pkg::ChanW-1:0]    r, g, b;
    logic [bbe_pkg::CfgIdxW-1:0]  idx;
    logic [bbe_pkg::CfgDataW-1:0] data;
  } step_t;

  typedef struct {
    logic [bbe_pkg::ChanW-1:0] r, g, b;
    logic                      fe;
  } blur_pix_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0, in_valid = 1'b0, out_ready = 1'b0;
  logic [bbe_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [bbe_pkg::CfgDataW-1:0] cfg_data = '0;
  logic opcode = bbe_pkg::OpPixel;
  logic [bbe_pkg::ChanW-1:0] red_in = '0, green_in = '0, blue_in = '0;
  logic cfg_ready, in_ready, out_valid, frame_end;
  logic [bbe_pkg::ChanW-1:0] red_out, green_out, blue_out;

  step_t     stim_q[$];
  blur_pix_t blur_exp_q[$];
  int        errors = 0;
  int        quiet = 0;
  int        idle_cnt = 0;
  int        items_sent = 0;
  int        beats_seen = 0;
  logic      in_fire_q = 1'b0, cfg_fire_q = 1'b0;
  logic      held_once = 1'b0;
  int        hold_left = 0;

  // predictor state
  logic [bbe_pkg::PixW-1:0] lines [3][MaxW];
  logic [bbe_pkg::FwW-1:0]  p_width = 11'd1024;
  logic [bbe_pkg::FhW-1:0]  p_height = 16'd1024;
  int                       p_col = 0, p_row = 0, p_pend = 0;

  box_blur_3x3_edge_aware DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .opcode_i(opcode), .red_in_i(red_in), .green_in_i(green_in), .blue_in_i(blue_in),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .red_out_o(red_out), .green_out_o(green_out), .blue_out_o(blue_out),
    .frame_end_o(frame_end)
  );

  always #10 clk = ~clk;

  function automatic int eff_w();
    if (p_width == 0) return 1;
    if (p_width > MaxW) return MaxW;
    return p_width;
  endfunction

  function automatic int eff_h();
    return (p_height == 0) ? 1 : p_height;
  endfunction

  function automatic blur_pix_t blur_at(int r, int c, logic last);
    blur_pix_t res;
    int w, h, sr, sg, sb, n, rr, cc;
    logic [bbe_pkg::PixW-1:0] px;
    w = eff_w(); h = eff_h();
    sr = 0; sg = 0; sb = 0; n = 0;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        rr = r + dr; cc = c + dc;
        if (rr < 0 || cc < 0 || rr >= h || cc >= w) continue;
        px = lines[rr % 3][cc];
        sr += px[23:16]; sg += px[15:8]; sb += px[7:0];
        n++;
      end
    end
    if (n == 0) n = 1;
    res.r = 8'((2 * sr + n) / (2 * n));
    res.g = 8'((2 * sg + n) / (2 * n));
    res.b = 8'((2 * sb + n) / (2 * n));
    res.fe = last;
    return res;
  endfunction

  function automatic void predict_blur(logic op, logic [bbe_pkg::ChanW-1:0] r, g, b);
    int w, h;
    w = eff_w(); h = eff_h();
    if (op == bbe_pkg::OpPixel) begin
      if (p_pend != 0 || p_row >= h || p_col >= w) return;
      lines[p_row % 3][p_col] = {r, g, b};
      if (p_row >= 1) begin
        if (p_col >= 1) blur_exp_q.push_back(blur_at(p_row - 1, p_col - 1, 1'b0));
        if (p_col == w - 1) blur_exp_q.push_back(blur_at(p_row - 1, p_col, 1'b0));
      end
      p_col++;
      if (p_col == w) begin
        p_col = 0;
        p_row++;
        if (p_row == h) p_pend = w;
      end
    end else begin
      if (p_pend == 0) return;
      blur_exp_q.push_back(blur_at(h - 1, w - p_pend, p_pend == 1));
      p_pend--;
      if (p_pend == 0) begin
        p_row = 0; p_col = 0;
      end
    end
  endfunction

  function automatic void apply_cfg(logic [bbe_pkg::CfgIdxW-1:0] idx,
                                    logic [bbe_pkg::CfgDataW-1:0] d);
    if (idx == bbe_pkg::RegFrameWidth) p_width = d[bbe_pkg::FwW-1:0];
    else if (idx == bbe_pkg::RegFrameHeight) p_height = d;
    else return;
    p_col = 0; p_row = 0; p_pend = 0;
  endfunction

  // check, then predict
  always @(posedge clk) begin
    blur_pix_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        beats_seen++;
        if (blur_exp_q.size() == 0) begin
          $error("unexpected output beat r=%0d g=%0d b=%0d", red_out, green_out, blue_out);
          errors++;
        end else begin
          e = blur_exp_q.pop_front();
          if (red_out !== e.r) begin
            $error("red_out exp %0d got %0d", e.r, red_out); errors++;
          end
          if (green_out !== e.g) begin
            $error("green_out exp %0d got %0d", e.g, green_out); errors++;
          end
          if (blue_out !== e.b) begin
            $error("blue_out exp %0d got %0d", e.b, blue_out); errors++;
          end
          if (frame_end !== e.fe) begin
            $error("frame_end exp %0d got %0d", e.fe, frame_end); errors++;
          end
        end
      end
      if (in_valid && in_ready) predict_blur(opcode, red_in, green_in, blue_in);
      if (cfg_valid && cfg_ready) apply_cfg(cfg_index, cfg_data);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet <= 0; idle_cnt <= 0;
      end else begin
        quiet <= quiet + 1; idle_cnt <= idle_cnt + 1;
      end
      in_fire_q <= in_valid && in_ready;
      cfg_fire_q <= cfg_valid && cfg_ready;
    end
  end

  // driver
  always @(negedge clk) begin
    logic nv_in, nv_cfg, calm;
    step_t s;
    nv_in = in_valid & ~in_fire_q;
    nv_cfg = cfg_valid & ~cfg_fire_q;
    calm = (items_sent > 300 && items_sent < 500);
    if (rst_n && !nv_in && !nv_cfg && stim_q.size() > 0) begin
      s = stim_q[0];
      case (s.kind)
        KPix: begin
          if (calm || $urandom_range(0, 99) >= 9) begin
            void'(stim_q.pop_front());
            opcode <= s.op; red_in <= s.r; green_in <= s.g; blue_in <= s.b;
            nv_in = 1'b1;
            items_sent++;
          end
        end
        KCfg: begin
          if (blur_exp_q.size() == 0 && quiet >= QuietCycles) begin
            void'(stim_q.pop_front());
            cfg_index <= s.idx; cfg_data <= s.data;
            nv_cfg = 1'b1;
          end
        end
        default: begin
          if (blur_exp_q.size() == 0) void'(stim_q.pop_front());
        end
      endcase
    end
    in_valid <= nv_in;
    cfg_valid <= nv_cfg;
  end

  // receiver
  always @(negedge clk) begin
    if (!held_once && beats_seen >= 200) begin
      held_once <= 1'b1;
      hold_left <= 600;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (beats_seen > 400 && beats_seen < 600) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= 9);
    end
  end

  always @(posedge clk) begin
    if (idle_cnt >= WatchdogLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic add_pix(logic [bbe_pkg::ChanW-1:0] r, g, b);
    stim_q.push_back('{KPix, bbe_pkg::OpPixel, r, g, b, '0, '0});
  endtask

  task automatic add_drain();
    stim_q.push_back('{KPix, bbe_pkg::OpDrain, 8'($urandom), 8'($urandom), 8'($urandom),
                       '0, '0});
  endtask

  task automatic add_cfg(logic [bbe_pkg::CfgIdxW-1:0] idx, logic [bbe_pkg::CfgDataW-1:0] d);
    stim_q.push_back('{KCfg, bbe_pkg::OpPixel, '0, '0, '0, idx, d});
  endtask

  task automatic add_sync();
    stim_q.push_back('{KSync, bbe_pkg::OpPixel, '0, '0, '0, '0, '0});
  endtask

  task automatic add_frame(int w, int h, logic broken);
    int n;
    n = broken ? $urandom_range(1, w * h) : w * h;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 4) add_drain();
      add_pix(8'($urandom), 8'($urandom), 8'($urandom));
    end
    if (broken) return;
    if ($urandom_range(0, 9) == 0) add_pix(8'($urandom), 8'($urandom), 8'($urandom));
    for (int i = 0; i < w; i++) add_drain();
    if ($urandom_range(0, 9) == 0) add_drain();
  endtask

  initial begin
    int w, h, cnt;
    add_cfg(bbe_pkg::RegFrameWidth, 16'd3);
    add_cfg(bbe_pkg::RegFrameHeight, 16'd3);
    add_pix(8'd255, 8'd255, 8'd255); add_pix(8'd0, 8'd0, 8'd0);
    add_pix(8'd255, 8'd0, 8'd255);   add_pix(8'd1, 8'd254, 8'd128);
    add_pix(8'd255, 8'd255, 8'd255); add_pix(8'd0, 8'd0, 8'd0);
    add_pix(8'd127, 8'd128, 8'd3);   add_pix(8'd0, 8'd255, 8'd0);
    add_pix(8'd255, 8'd255, 8'd255);
    add_pix(8'd9, 8'd9, 8'd9);
    add_drain(); add_drain(); add_drain(); add_drain();
    add_sync();
    add_cfg(bbe_pkg::RegFrameWidth, 16'd0);
    add_cfg(bbe_pkg::RegFrameHeight, 16'd0);
    add_pix(8'd200, 8'd17, 8'd99); add_drain();
    add_cfg(RegSpare2, 16'hFFFF);
    add_cfg(RegSpare3, 16'h0000);
    add_cfg(bbe_pkg::RegFrameWidth, 16'hFFFF);
    add_cfg(bbe_pkg::RegFrameHeight, 16'd1);
    for (int i = 0; i < 100; i++) add_pix(8'($urandom), 8'($urandom), 8'($urandom));
    add_drain();
    add_cfg(bbe_pkg::RegFrameWidth, 16'd2);
    add_cfg(bbe_pkg::RegFrameHeight, 16'hFFFF);
    add_frame(2, 4, 1'b1);
    cnt = 0;
    while (cnt < 600) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 8);
      h = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 6);
      add_cfg(bbe_pkg::RegFrameWidth, {5'($urandom), 11'(w)});
      add_cfg(bbe_pkg::RegFrameHeight, 16'(h));
      if (h == 0) h = 1;
      for (int f = $urandom_range(1, 3); f > 0; f--) begin
        add_frame(w, h, $urandom_range(0, 9) == 0);
        cnt += w * h + w;
        if ($urandom_range(0, 7) == 0) add_sync();
      end
      add_sync();
    end
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;
    wait (stim_q.size() == 0 && !in_valid && !cfg_valid && blur_exp_q.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0 && blur_exp_q.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
